// ----- rtl/complex_arithmetic_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit assertion macros
// Concurrent assertion wrappers; empty when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_ASSERT_SVH

`ifndef SYNTH
`define CAU_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define CAU_ASSERT_IMP(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
`else
`define CAU_ASSERT(label, cond, msg)
`define CAU_ASSERT_IMP(label, pre, post, msg)
`endif

`endif

// ----- rtl/cau_pkg.sv -----
// ----------------------------------------------------------------------------
// Complex arithmetic unit package
// Opcodes, status codes, pipeline types and sign-magnitude helpers.
// ----------------------------------------------------------------------------
package cau_pkg;

  localparam int DefFracBits = 16;
  localparam int QuotBits    = 33;
  localparam int PaddrW      = 3;
  localparam logic [PaddrW-1:0] RegZeroTolAddr = 3'd0;

  typedef enum logic [3:0] {
    FN_ADD      = 4'd0,
    FN_SUB      = 4'd1,
    FN_NEG      = 4'd2,
    FN_CONJ     = 4'd3,
    FN_MUL      = 4'd4,
    FN_MUL_REAL = 4'd5,
    FN_DIV_REAL = 4'd6,
    FN_DIV      = 4'd7,
    FN_SQUARE   = 4'd8
  } func_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_DIVZERO = 2'd1,
    ST_OVF     = 2'd2
  } status_t;

  typedef struct packed {
    logic        neg;
    logic [63:0] mag;
  } smag_t;

  typedef struct packed {
    logic [31:0] val;
    logic        ovf;
  } packed_t;

  // One word in the divider part of the pipeline.
  typedef struct packed {
    logic                dz;
    logic                is_div;
    logic                hi_re;
    logic                hi_im;
    logic                re_neg;
    logic                im_neg;
    logic [63:0]         re_mag;
    logic [63:0]         im_mag;
    logic [63:0]         den;
    logic [QuotBits-1:0] q_re;
    logic [QuotBits-1:0] q_im;
  } pipe_t;

  function automatic smag_t sm_add(smag_t x, smag_t y);
    smag_t r;
    if (x.neg == y.neg) begin
      r.neg = x.neg;
      r.mag = x.mag + y.mag;
    end else if (x.mag >= y.mag) begin
      r.neg = x.neg;
      r.mag = x.mag - y.mag;
    end else begin
      r.neg = y.neg;
      r.mag = y.mag - x.mag;
    end
    return r;
  endfunction

  function automatic smag_t sm_flip(smag_t x);
    smag_t r;
    r.neg = ~x.neg;
    r.mag = x.mag;
    return r;
  endfunction

  // Clamp to 32-bit two's complement.
  function automatic packed_t sm_pack(logic neg, logic [63:0] mag);
    packed_t     r;
    logic [63:0] limit;
    logic [63:0] m;
    limit = neg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_7FFF_FFFF;
    m     = mag;
    r.ovf = 1'b0;
    if (m > limit) begin
      m     = limit;
      r.ovf = 1'b1;
    end
    r.val = neg ? (32'd0 - m[31:0]) : m[31:0];
    return r;
  endfunction

endpackage

// ----- rtl/cau_div_step.sv -----
// ----------------------------------------------------------------------------
// Divider step
// One restoring division step: trial subtract of the shifted divisor.
// ----------------------------------------------------------------------------
module cau_div_step #(
  parameter int SHIFT = 0
) (
  input  logic [63:0] rem,
  input  logic [63:0] den,
  output logic [63:0] rem_next,
  output logic        qbit
);
  import cau_pkg::*;

  logic [63+QuotBits:0] rem_w;
  logic [63+QuotBits:0] trial;

  always_comb begin
    rem_w    = {{QuotBits{1'b0}}, rem};
    trial    = {{QuotBits{1'b0}}, den} << SHIFT;
    qbit     = (rem_w >= trial);
    rem_next = qbit ? 64'(rem_w - trial) : rem;
  end

endmodule

// ----- rtl/complex_arithmetic_unit.sv -----
// Throughput: one word per cycle; the pipeline holds as a whole only while
// the output word waits for m_tready.
// The divide section is a 33-stage restoring divider, one quotient bit a stage.
// Reset (rst, synchronous): empties the pipeline and clears zero_tolerance.
// ----------------------------------------------------------------------------
// Complex arithmetic unit
// Pipelined Q-format complex ALU: add, sub, neg, conj, mul, square, scale, divides.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit #(
  parameter int FRAC_BITS = cau_pkg::DefFracBits
) (
  input  logic                        clk,
  input  logic                        rst,
  // APB configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cau_pkg::PaddrW-1:0]  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  // Input stream
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // fields low to high: func[3:0], a_re, a_im, b_re, b_im, real_factor, 4'b0
  input  logic [167:0]                s_tdata,
  // Output stream
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // fields low to high: res_re[31:0], res_im[63:32], status[65:64], 6'b0
  output logic [71:0]                 m_tdata
);
  import cau_pkg::*;

  `include "complex_arithmetic_unit_assert.svh"

  localparam int NSteps = QuotBits;

  // --------------------------------------------------------------------------
  // Configuration register
  // --------------------------------------------------------------------------
  logic [15:0] zero_tolerance;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_tolerance <= '0;
    end else if (psel && penable && pwrite && pready && paddr == RegZeroTolAddr) begin
      zero_tolerance <= pwdata[15:0];
    end
  end
  assign prdata = (paddr == RegZeroTolAddr) ? {16'd0, zero_tolerance} : 32'd0;

  // --------------------------------------------------------------------------
  // Global advance: every stage moves while the output slot is free or taken.
  // --------------------------------------------------------------------------
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // --------------------------------------------------------------------------
  // Stage 1: unpack, take magnitudes, pick multiplier operands
  // --------------------------------------------------------------------------
  logic [31:0] in_f [5];
  logic [3:0]  in_func;
  always_comb begin
    in_func = s_tdata[3:0];
    for (int i = 0; i < 5; i++) begin
      in_f[i] = s_tdata[4+32*i +: 32];
    end
  end

  // Operand order: 0 a_re, 1 a_im, 2 b_re, 3 b_im, 4 real_factor, 5 b0, 6 b1
  logic        v1;
  logic [3:0]  func1;
  logic        sg1 [7];
  logic [31:0] mg1 [7];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (adv) begin
      v1 <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      func1 <= in_func;
      for (int i = 0; i < 5; i++) begin
        sg1[i] <= in_f[i][31];
        mg1[i] <= in_f[i][31] ? (32'd0 - in_f[i]) : in_f[i];
      end
      // Square reuses a as the second operand, scaling uses the real factor.
      if (in_func == FN_SQUARE) begin
        sg1[5] <= in_f[0][31];
        mg1[5] <= in_f[0][31] ? (32'd0 - in_f[0]) : in_f[0];
        sg1[6] <= in_f[1][31];
        mg1[6] <= in_f[1][31] ? (32'd0 - in_f[1]) : in_f[1];
      end else if (in_func == FN_MUL_REAL) begin
        sg1[5] <= in_f[4][31];
        mg1[5] <= in_f[4][31] ? (32'd0 - in_f[4]) : in_f[4];
        sg1[6] <= in_f[4][31];
        mg1[6] <= in_f[4][31] ? (32'd0 - in_f[4]) : in_f[4];
      end else begin
        sg1[5] <= in_f[2][31];
        mg1[5] <= in_f[2][31] ? (32'd0 - in_f[2]) : in_f[2];
        sg1[6] <= in_f[3][31];
        mg1[6] <= in_f[3][31] ? (32'd0 - in_f[3]) : in_f[3];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: six exact 32x32 magnitude products
  //   p0 ar*b0, p1 ai*b1, p2 ar*b1, p3 ai*b0, p4 br*br, p5 bi*bi
  // --------------------------------------------------------------------------
  logic        v2;
  logic [3:0]  func2;
  logic        sg2 [5];
  logic [31:0] mg2 [5];
  smag_t       p2  [6];

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (adv) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      func2 <= func1;
      for (int i = 0; i < 5; i++) begin
        sg2[i] <= sg1[i];
        mg2[i] <= mg1[i];
      end
      p2[0] <= '{neg: sg1[0] ^ sg1[5], mag: 64'(mg1[0]) * 64'(mg1[5])};
      p2[1] <= '{neg: sg1[1] ^ sg1[6], mag: 64'(mg1[1]) * 64'(mg1[6])};
      p2[2] <= '{neg: sg1[0] ^ sg1[6], mag: 64'(mg1[0]) * 64'(mg1[6])};
      p2[3] <= '{neg: sg1[1] ^ sg1[5], mag: 64'(mg1[1]) * 64'(mg1[5])};
      p2[4] <= '{neg: 1'b0,            mag: 64'(mg1[2]) * 64'(mg1[2])};
      p2[5] <= '{neg: 1'b0,            mag: 64'(mg1[3]) * 64'(mg1[3])};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3: combine products, form results or dividend/divisor, zero test
  // --------------------------------------------------------------------------
  smag_t ar3, ai3, br3, bi3;
  smag_t re3, im3, sum3;
  logic [63:0] den3;
  logic        dz3, isdiv3;
  pipe_t       e3;

  always_comb begin
    ar3    = '{neg: sg2[0], mag: 64'(mg2[0])};
    ai3    = '{neg: sg2[1], mag: 64'(mg2[1])};
    br3    = '{neg: sg2[2], mag: 64'(mg2[2])};
    bi3    = '{neg: sg2[3], mag: 64'(mg2[3])};
    re3    = '0;
    im3    = '0;
    sum3   = '0;
    den3   = '0;
    dz3    = 1'b0;
    isdiv3 = 1'b0;
    case (func2)
      FN_ADD: begin
        re3 = sm_add(ar3, br3);
        im3 = sm_add(ai3, bi3);
      end
      FN_SUB: begin
        re3 = sm_add(ar3, sm_flip(br3));
        im3 = sm_add(ai3, sm_flip(bi3));
      end
      FN_NEG: begin
        re3 = sm_flip(ar3);
        im3 = sm_flip(ai3);
      end
      FN_CONJ: begin
        re3 = ar3;
        im3 = sm_flip(ai3);
      end
      FN_MUL, FN_SQUARE: begin
        re3     = sm_add(p2[0], sm_flip(p2[1]));
        im3     = sm_add(p2[2], p2[3]);
        re3.mag = re3.mag >> FRAC_BITS;
        im3.mag = im3.mag >> FRAC_BITS;
      end
      FN_MUL_REAL: begin
        re3.neg = p2[0].neg;
        re3.mag = p2[0].mag >> FRAC_BITS;
        im3.neg = p2[3].neg;
        im3.mag = p2[3].mag >> FRAC_BITS;
      end
      FN_DIV_REAL: begin
        isdiv3  = 1'b1;
        re3.neg = sg2[0] ^ sg2[4];
        re3.mag = 64'(mg2[0]) << FRAC_BITS;
        im3.neg = sg2[1] ^ sg2[4];
        im3.mag = 64'(mg2[1]) << FRAC_BITS;
        den3    = 64'(mg2[4]);
        dz3     = den3 <= 64'(zero_tolerance);
      end
      FN_DIV: begin
        // a * conj(b) over |b|^2, the divisor truncated to the Q format
        isdiv3   = 1'b1;
        re3      = sm_add(p2[0], p2[1]);
        im3      = sm_add(p2[3], sm_flip(p2[2]));
        sum3.mag = p2[4].mag + p2[5].mag;
        den3     = sum3.mag >> FRAC_BITS;
        dz3      = den3 <= 64'(zero_tolerance);
      end
      default: begin
        re3 = '0;
        im3 = '0;
      end
    endcase
    e3.dz     = dz3;
    e3.is_div = isdiv3;
    e3.hi_re  = 1'b0;
    e3.hi_im  = 1'b0;
    e3.re_neg = re3.neg;
    e3.im_neg = im3.neg;
    e3.re_mag = re3.mag;
    e3.im_mag = im3.mag;
    e3.den    = den3;
    e3.q_re   = '0;
    e3.q_im   = '0;
  end

  logic  v3;
  pipe_t r3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (adv) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      r3 <= e3;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4: flag quotients too large for the divider (saturate later)
  // --------------------------------------------------------------------------
  logic  vp [NSteps+1];
  pipe_t pp [NSteps+1];
  pipe_t pp0_next;

  always_comb begin
    pp0_next       = r3;
    pp0_next.hi_re = (r3.re_mag >> QuotBits) >= r3.den;
    pp0_next.hi_im = (r3.im_mag >> QuotBits) >= r3.den;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vp[0] <= 1'b0;
    end else if (adv) begin
      vp[0] <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pp[0] <= pp0_next;
    end
  end

  // --------------------------------------------------------------------------
  // Divider stages: quotient bit NSteps-1-k at stage k, both lanes at once
  // --------------------------------------------------------------------------
  for (genvar k = 0; k < NSteps; k++) begin : g_div
    logic [63:0] rem_re_next, rem_im_next;
    logic        qb_re, qb_im;
    pipe_t       pp_next;

    cau_div_step #(.SHIFT(NSteps - 1 - k)) u_step_re (
      .rem      (pp[k].re_mag),
      .den      (pp[k].den),
      .rem_next (rem_re_next),
      .qbit     (qb_re)
    );

    cau_div_step #(.SHIFT(NSteps - 1 - k)) u_step_im (
      .rem      (pp[k].im_mag),
      .den      (pp[k].den),
      .rem_next (rem_im_next),
      .qbit     (qb_im)
    );

    // Non-divide words pass with their result untouched.
    always_comb begin
      pp_next = pp[k];
      if (pp[k].is_div) begin
        pp_next.re_mag               = rem_re_next;
        pp_next.im_mag               = rem_im_next;
        pp_next.q_re[NSteps - 1 - k] = qb_re;
        pp_next.q_im[NSteps - 1 - k] = qb_im;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vp[k+1] <= 1'b0;
      end else if (adv) begin
        vp[k+1] <= vp[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        pp[k+1] <= pp_next;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Final stage: saturate, set status, hold the output word
  // --------------------------------------------------------------------------
  pipe_t       fin;
  logic [63:0] mag_re, mag_im;
  packed_t     pk_re, pk_im;
  logic [31:0] res_re, res_im;
  status_t     status;

  always_comb begin
    fin = pp[NSteps];
    if (fin.is_div) begin
      mag_re = fin.hi_re ? '1 : 64'(fin.q_re);
      mag_im = fin.hi_im ? '1 : 64'(fin.q_im);
    end else begin
      mag_re = fin.re_mag;
      mag_im = fin.im_mag;
    end
    pk_re = sm_pack(fin.re_neg, mag_re);
    pk_im = sm_pack(fin.im_neg, mag_im);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= vp[NSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fin.dz) begin
        res_re <= '0;
        res_im <= '0;
        status <= ST_DIVZERO;
      end else begin
        res_re <= pk_re.val;
        res_im <= pk_im.val;
        status <= (pk_re.ovf || pk_im.ovf) ? ST_OVF : ST_OK;
      end
    end
  end

  assign m_tdata = {6'd0, status, res_im, res_re};

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  `CAU_ASSERT(a_ready_rule, s_tready == (!m_tvalid || m_tready), "s_tready mismatch")
  `CAU_ASSERT_IMP(a_dz_zero, m_tvalid && status == ST_DIVZERO, res_re == 32'd0 && res_im == 32'd0, "divide by zero result not zero")
  `CAU_ASSERT_IMP(a_status_code, m_tvalid, status == ST_OK || status == ST_DIVZERO || status == ST_OVF, "bad status")

endmodule
